>>> sv/fsrd_pkg.sv
// fsrd_pkg: types, constants and the byte position layout table of the
// fan status record decoder
// no dependencies
package fsrd_pkg;

    // record geometry and decode limits
    localparam int unsigned RecLen = 28;
    localparam logic [4:0] RecLenPos = 5'(RecLen);
    localparam logic [4:0] LastField = 5'd18;
    localparam logic [7:0] OneErrLimit = 8'd200;
    localparam logic [7:0] TwoErrLimit = 8'h7F;
    localparam logic [7:0] InfoMask = 8'h1F;

    // what a byte position contributes
    typedef enum logic [2:0] {
        POS_HIGH      = 3'd0,
        POS_ONE_PLAIN = 3'd1,
        POS_ONE_SENS  = 3'd2,
        POS_ONE_HEAT  = 3'd3,
        POS_TWO_PLAIN = 3'd4,
        POS_TWO_ERR   = 3'd5,
        POS_INFO      = 3'd6
    } pos_kind_t;

    typedef enum logic [1:0] {
        KIND_MEAS  = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_INFO  = 2'd2
    } result_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_SENSOR   = 2'd1,
        ERR_HEAT     = 2'd2,
        ERR_SENSOR16 = 2'd3
    } error_table_t;

    typedef enum logic [1:0] {
        SCALE_UNITS      = 2'd0,
        SCALE_HALVES     = 2'd1,
        SCALE_HUNDREDTHS = 2'd2
    } scale_t;

    typedef struct packed {
        logic [4:0] field;
        pos_kind_t  kind;
        scale_t     scale;
        logic [4:0] gate;
    } layout_entry_t;

    // one decoded result item
    typedef struct packed {
        logic [4:0]   field_index;
        logic [15:0]  field_value;
        result_kind_t result_kind;
        error_table_t error_table;
        scale_t       scale_code;
    } result_t;

    // fixed record layout, one entry per byte position
    function automatic layout_entry_t layout_lookup(input logic [4:0] pos);
        layout_entry_t e;
        case (pos)
            5'd0:    e = '{5'd0,  POS_ONE_SENS,  SCALE_UNITS,      5'd0};
            5'd1:    e = '{5'd1,  POS_ONE_PLAIN, SCALE_UNITS,      5'd0};
            5'd2:    e = '{5'd0,  POS_HIGH,      SCALE_UNITS,      5'd0};
            5'd3:    e = '{5'd2,  POS_TWO_ERR,   SCALE_UNITS,      5'd1};
            5'd4:    e = '{5'd3,  POS_ONE_SENS,  SCALE_UNITS,      5'd3};
            5'd5:    e = '{5'd4,  POS_ONE_SENS,  SCALE_HALVES,     5'd4};
            5'd6:    e = '{5'd0,  POS_HIGH,      SCALE_UNITS,      5'd0};
            5'd7:    e = '{5'd5,  POS_TWO_ERR,   SCALE_HUNDREDTHS, 5'd5};
            5'd8:    e = '{5'd0,  POS_HIGH,      SCALE_UNITS,      5'd0};
            5'd9:    e = '{5'd6,  POS_TWO_ERR,   SCALE_HUNDREDTHS, 5'd7};
            5'd10:   e = '{5'd0,  POS_HIGH,      SCALE_UNITS,      5'd0};
            5'd11:   e = '{5'd7,  POS_TWO_ERR,   SCALE_HUNDREDTHS, 5'd9};
            5'd12:   e = '{5'd0,  POS_HIGH,      SCALE_UNITS,      5'd0};
            5'd13:   e = '{5'd8,  POS_TWO_ERR,   SCALE_HUNDREDTHS, 5'd11};
            5'd14:   e = '{5'd0,  POS_HIGH,      SCALE_UNITS,      5'd0};
            5'd15:   e = '{5'd9,  POS_TWO_PLAIN, SCALE_UNITS,      5'd13};
            5'd16:   e = '{5'd10, POS_ONE_SENS,  SCALE_HALVES,     5'd15};
            5'd17:   e = '{5'd11, POS_INFO,      SCALE_UNITS,      5'd16};
            5'd18:   e = '{5'd12, POS_ONE_SENS,  SCALE_HALVES,     5'd17};
            5'd19:   e = '{5'd13, POS_ONE_SENS,  SCALE_HALVES,     5'd18};
            5'd20:   e = '{5'd0,  POS_HIGH,      SCALE_UNITS,      5'd0};
            5'd21:   e = '{5'd14, POS_TWO_PLAIN, SCALE_UNITS,      5'd19};
            5'd22:   e = '{5'd15, POS_ONE_HEAT,  SCALE_HALVES,     5'd21};
            5'd23:   e = '{5'd16, POS_ONE_HEAT,  SCALE_HALVES,     5'd22};
            5'd24:   e = '{5'd0,  POS_HIGH,      SCALE_UNITS,      5'd0};
            5'd25:   e = '{5'd17, POS_TWO_ERR,   SCALE_HUNDREDTHS, 5'd23};
            5'd26:   e = '{5'd0,  POS_HIGH,      SCALE_UNITS,      5'd0};
            5'd27:   e = '{5'd18, POS_TWO_ERR,   SCALE_HUNDREDTHS, 5'd25};
            default: e = '{5'd0,  POS_HIGH,      SCALE_UNITS,      5'd0};
        endcase
        return e;
    endfunction

endpackage

>>> sv/fsrd_decode.sv
// fsrd_decode: record position tracking, held high byte and the
// combinational field decode of one accepted byte
// depends on fsrd_pkg
module fsrd_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic [7:0]        declared_length,
    input  logic              start_of_record,
    output logic              result_valid,
    output fsrd_pkg::result_t result
);

    logic [4:0]              byte_position_reg;
    logic [4:0]              byte_position_next;
    logic [7:0]              held_high_byte_reg;
    logic [7:0]              held_high_byte_next;
    logic [4:0]              pos;
    logic                    in_record;
    logic                    gate_ok;
    fsrd_pkg::layout_entry_t entry;

    // position of this byte and its layout entry
    assign pos       = start_of_record ? 5'd0 : byte_position_reg;
    assign in_record = (pos < fsrd_pkg::RecLenPos);
    assign entry     = fsrd_pkg::layout_lookup(pos);
    assign gate_ok   = (declared_length > {3'd0, entry.gate});

    // next state of position and held byte
    always_comb begin
        byte_position_next  = byte_position_reg;
        held_high_byte_next = held_high_byte_reg;
        if (accept) begin
            if (in_record) begin
                byte_position_next = pos + 5'd1;
                if (entry.kind == fsrd_pkg::POS_HIGH) begin
                    held_high_byte_next = data_byte;
                end
            end else begin
                byte_position_next = fsrd_pkg::RecLenPos;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg  <= 5'd0;
            held_high_byte_reg <= 8'd0;
        end else begin
            byte_position_reg  <= byte_position_next;
            held_high_byte_reg <= held_high_byte_next;
        end
    end

    // field decode
    always_comb begin
        result_valid       = accept && in_record && gate_ok
                             && (entry.kind != fsrd_pkg::POS_HIGH);
        result.field_index = entry.field;
        result.field_value = {8'd0, data_byte};
        result.result_kind = fsrd_pkg::KIND_MEAS;
        result.error_table = fsrd_pkg::ERR_NONE;
        result.scale_code  = entry.scale;
        case (entry.kind)
            fsrd_pkg::POS_ONE_SENS, fsrd_pkg::POS_ONE_HEAT: begin
                if (data_byte > fsrd_pkg::OneErrLimit) begin
                    result.result_kind = fsrd_pkg::KIND_ERROR;
                    result.scale_code  = fsrd_pkg::SCALE_UNITS;
                    result.error_table = (entry.kind == fsrd_pkg::POS_ONE_SENS)
                                         ? fsrd_pkg::ERR_SENSOR : fsrd_pkg::ERR_HEAT;
                end
            end
            fsrd_pkg::POS_TWO_ERR: begin
                if (held_high_byte_reg >= fsrd_pkg::TwoErrLimit) begin
                    result.field_value = {8'd0, held_high_byte_reg};
                    result.result_kind = fsrd_pkg::KIND_ERROR;
                    result.error_table = fsrd_pkg::ERR_SENSOR16;
                    result.scale_code  = fsrd_pkg::SCALE_UNITS;
                end else begin
                    result.field_value = {held_high_byte_reg, data_byte};
                end
            end
            fsrd_pkg::POS_TWO_PLAIN: begin
                result.field_value = {held_high_byte_reg, data_byte};
            end
            fsrd_pkg::POS_INFO: begin
                result.field_value = {8'd0, data_byte & fsrd_pkg::InfoMask};
                result.result_kind = fsrd_pkg::KIND_INFO;
                result.scale_code  = fsrd_pkg::SCALE_UNITS;
            end
            default: begin
                result.field_value = {8'd0, data_byte};
            end
        endcase
    end

    // position never runs past the record end
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_position_reg <= fsrd_pkg::RecLenPos)
        else $error("byte position beyond record end");

    // a result only names a real field
    a_field_range: assert property (@(posedge aclk) disable iff (!aresetn)
        result_valid |-> (result.field_index <= fsrd_pkg::LastField))
        else $error("field index out of range");

    // error and info results carry no scale
    a_err_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        (result_valid && (result.result_kind != fsrd_pkg::KIND_MEAS))
        |-> (result.scale_code == fsrd_pkg::SCALE_UNITS))
        else $error("scaled error or info result");

    // a byte past the record end leaves the position saturated
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !in_record) |=> (byte_position_reg == fsrd_pkg::RecLenPos))
        else $error("position left saturation");

endmodule

>>> sv/fsrd_skid.sv
// fsrd_skid: result register with one skid entry, so a new item is
// taken while a finished result still waits downstream
// depends on fsrd_pkg
module fsrd_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  fsrd_pkg::result_t push_data,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output fsrd_pkg::result_t out_data
);

    logic              main_valid_reg;
    logic              main_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    fsrd_pkg::result_t main_data_reg;
    fsrd_pkg::result_t main_data_next;
    fsrd_pkg::result_t skid_data_reg;
    fsrd_pkg::result_t skid_data_next;

    assign room      = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // refill the result register from skid first, then from the decoder
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    // skid entry is only used behind a waiting result
    a_skid_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid holds data with empty result register");

    // no item arrives while the skid entry is occupied
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !skid_valid_reg)
        else $error("push into full buffer");

    // a stalled skid entry moves forward once the result is taken
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && out_ready) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid entry not drained");

endmodule

>>> sv/fan_status_record_decoder_unit.sv
// fan_status_record_decoder_unit: top level of the fan status record decoder
// depends on fsrd_pkg, fsrd_decode, fsrd_skid
//
// channel | dir | tdata (low bit up)                  | tuser (low bit up)
// s_      | in  | data_byte[7:0], declared_length[7:0] | start_of_record
// m_      | out | field_index[4:0], field_value[15:0]  | result_kind[1:0],
//         |     |   (zero pad to 24 bits)             | error_table, scale_code
//
// one byte per cycle is accepted while s_tready is high; a result goes from
// the combinational decode table into one result register, or into the skid entry.
// reset clears the record position and held high byte, so bytes before a
// start mark count from position zero.
// a stalled m_ side is absorbed by one skid entry; s_tready drops only
// while that entry is full, i.e. after two results are waiting.
module fan_status_record_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte, declared_length
    input  logic [0:0]  s_tuser,   // start_of_record
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // field_index, field_value, zero pad
    output logic [5:0]  m_tuser    // result_kind, error_table, scale_code
);

    logic              accept;
    logic              result_valid;
    fsrd_pkg::result_t result;
    fsrd_pkg::result_t out_result;

    assign accept = s_tvalid && s_tready;

    // per-byte decode and record state
    fsrd_decode u_decode (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .data_byte       (s_tdata[7:0]),
        .declared_length (s_tdata[15:8]),
        .start_of_record (s_tuser[0]),
        .result_valid    (result_valid),
        .result          (result)
    );

    // result register and skid entry
    fsrd_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (result_valid),
        .push_data (result),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    // pack result item
    assign m_tdata = {3'd0, out_result.field_value, out_result.field_index};
    assign m_tuser = {out_result.scale_code, out_result.error_table,
                      out_result.result_kind};

endmodule
